// ----- rtl/core/arr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder package
// Shared constants, result codes and the check verdict passed to the emitter.
// ----------------------------------------------------------------------------
package arr_pkg;

  localparam int FrameKeep = 42;   // bytes of a frame that are kept
  localparam int ArpLen    = 28;   // length of a bare ARP payload
  localparam int EthHdr    = 14;   // Ethernet header length
  localparam int CountMax  = 63;   // saturation value of the byte count
  localparam int CountW    = 6;
  localparam int MacW      = 48;
  localparam int IpW       = 32;

  localparam logic [15:0] EtherTypeArp = 16'h0806;
  localparam logic [15:0] ProtoIpv4    = 16'h0800;
  localparam logic [15:0] HwTypeEth    = 16'h0001;
  localparam logic [7:0]  HwLenMac     = 8'd6;
  localparam logic [7:0]  ProtoLenIp   = 8'd4;
  localparam logic [15:0] OpRequest    = 16'h0001;
  localparam logic [15:0] OpReply      = 16'h0002;

  // Result status codes.
  localparam logic [1:0] StatusReply   = 2'd0;
  localparam logic [1:0] StatusIgnored = 2'd1;
  localparam logic [1:0] StatusNoIf    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CfgLocalMac       = 3'd0;
  localparam logic [2:0] CfgInterfaceReady = 3'd1;
  localparam logic [2:0] CfgHeaderComplete = 3'd2;
  localparam logic [2:0] CfgNeighborCount  = 3'd3;
  localparam logic [2:0] CfgNeighbor0Ip    = 3'd4;
  localparam logic [2:0] CfgNeighbor0Mac   = 3'd5;
  localparam logic [2:0] CfgNeighbor1Ip    = 3'd6;
  localparam logic [2:0] CfgNeighbor1Mac   = 3'd7;

  typedef struct packed {
    logic            is_reply;
    logic [1:0]      status;
    logic [MacW-1:0] req_mac;
    logic [IpW-1:0]  req_ip;
    logic [MacW-1:0] nbr_mac;
    logic [IpW-1:0]  nbr_ip;
  } verdict_t;

endpackage

// ----- rtl/core/arr_capture.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder frame capture
// Keeps the first bytes of the incoming frame and a saturating byte count,
// and flags a finished frame for checking.
// ----------------------------------------------------------------------------
module arr_capture
  import arr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              frame_byte_i,
  input  logic                    frame_end_i,
  input  logic                    load_i,
  output logic                    eval_o,
  output logic [CountW-1:0]       total_o,
  output logic [FrameKeep*8-1:0]  store_o
);

  logic [CountW-1:0]      count_q, count_d;
  logic [CountW-1:0]      count_inc;
  logic [CountW-1:0]      total_q;
  logic                   eval_q, eval_d;
  logic [FrameKeep*8-1:0] store_q;
  logic                   accept;

  // A finished frame holds the store until the emitter takes its verdict.
  assign in_stall_o = eval_q && !load_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign count_inc = (count_q < CountW'(CountMax)) ? count_q + 1'b1 : count_q;

  always_comb begin
    count_d = count_q;
    eval_d  = eval_q;
    if (load_i) begin
      eval_d = 1'b0;
    end
    if (accept) begin
      count_d = frame_end_i ? '0 : count_inc;
      if (frame_end_i) begin
        eval_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      eval_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      eval_q  <= eval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && frame_end_i) begin
      total_q <= count_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && count_q < CountW'(FrameKeep)) begin
      store_q[8*count_q +: 8] <= frame_byte_i;
    end
  end

  assign eval_o  = eval_q;
  assign total_o = total_q;
  assign store_o = store_q;

endmodule

// ----- rtl/core/arr_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder frame check
// Decides from a captured frame whether to answer, and with which addresses.
// ----------------------------------------------------------------------------
module arr_check
  import arr_pkg::*;
(
  input  logic [FrameKeep*8-1:0] store_i,
  input  logic [CountW-1:0]      total_i,
  input  logic [MacW-1:0]        local_mac_i,
  input  logic                   interface_ready_i,
  input  logic                   src_strict_i,
  input  logic [1:0]             neighbor_count_i,
  input  logic [IpW-1:0]         nbr0_ip_i,
  input  logic [MacW-1:0]        nbr0_mac_i,
  input  logic [IpW-1:0]         nbr1_ip_i,
  input  logic [MacW-1:0]        nbr1_mac_i,
  output verdict_t               verdict_o
);

  logic [7:0]      arp [ArpLen];
  logic            full;
  logic            len_ok;
  logic            hdr_ok;
  logic [MacW-1:0] smac, dst, src;
  logic [IpW-1:0]  sip, tip;
  logic            hit0, hit1, hit;
  logic [MacW-1:0] nmac;
  logic [IpW-1:0]  nip;
  logic            sender_ok, dst_ok, src_ok, eth_ok;

  assign full   = total_i >= CountW'(FrameKeep);
  assign len_ok = full || total_i == CountW'(ArpLen);

  // The ARP part starts after the Ethernet header in a full frame.
  always_comb begin
    for (int i = 0; i < ArpLen; i++) begin
      arp[i] = full ? store_i[8*(EthHdr+i) +: 8] : store_i[8*i +: 8];
    end
  end

  assign hdr_ok = {arp[0], arp[1]} == HwTypeEth && {arp[2], arp[3]} == ProtoIpv4 &&
                  arp[4] == HwLenMac && arp[5] == ProtoLenIp &&
                  {arp[6], arp[7]} == OpRequest &&
                  (!full || {store_i[8*12 +: 8], store_i[8*13 +: 8]} == EtherTypeArp);

  assign smac = {arp[8], arp[9], arp[10], arp[11], arp[12], arp[13]};
  assign sip  = {arp[14], arp[15], arp[16], arp[17]};
  assign tip  = {arp[24], arp[25], arp[26], arp[27]};

  // Entry zero wins; a count of three acts as two.
  assign hit0 = neighbor_count_i != 2'd0 && nbr0_ip_i == tip;
  assign hit1 = neighbor_count_i[1] && nbr1_ip_i == tip;
  assign hit  = hit0 || hit1;
  assign nmac = hit0 ? nbr0_mac_i : nbr1_mac_i;
  assign nip  = hit0 ? nbr0_ip_i : nbr1_ip_i;

  assign sender_ok = smac == local_mac_i && !smac[40] && smac != '0;

  assign dst = {store_i[8*0 +: 8], store_i[8*1 +: 8], store_i[8*2 +: 8],
                store_i[8*3 +: 8], store_i[8*4 +: 8], store_i[8*5 +: 8]};
  assign src = {store_i[8*6 +: 8], store_i[8*7 +: 8], store_i[8*8 +: 8],
                store_i[8*9 +: 8], store_i[8*10 +: 8], store_i[8*11 +: 8]};
  assign dst_ok = dst == '1 || dst == nmac;
  assign src_ok = src == smac || (!src_strict_i && src == '0);
  assign eth_ok = !full || (dst_ok && src_ok);

  always_comb begin
    verdict_o.req_mac  = smac;
    verdict_o.req_ip   = sip;
    verdict_o.nbr_mac  = nmac;
    verdict_o.nbr_ip   = nip;
    verdict_o.is_reply = 1'b0;
    priority if (!interface_ready_i) begin
      verdict_o.status = StatusNoIf;
    end else if (len_ok && hdr_ok && hit && sender_ok && eth_ok) begin
      verdict_o.status   = StatusReply;
      verdict_o.is_reply = 1'b1;
    end else begin
      verdict_o.status = StatusIgnored;
    end
  end

endmodule

// ----- rtl/core/arr_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder result emitter
// Holds one verdict and sends either the reply frame byte by byte or a
// single status item.
// ----------------------------------------------------------------------------
module arr_emit
  import arr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       eval_i,
  input  verdict_t   verdict_i,
  output logic       load_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] reply_byte_o,
  output logic       last_of_run_o,
  output logic [1:0] status_o
);

  localparam logic [CountW-1:0] LastIdx = CountW'(FrameKeep - 1);

  logic                   busy_q, busy_d;
  logic [CountW-1:0]      idx_q, idx_d;
  verdict_t               vd_q;
  logic                   fire, last, free;
  logic [FrameKeep*8-1:0] reply_vec;
  logic [CountW-1:0]      sel;

  assign fire = busy_q && !out_stall_i;
  assign last = !vd_q.is_reply || idx_q == LastIdx;
  assign free = !busy_q || (fire && last);
  assign load_o = eval_i && free;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      vd_q <= verdict_i;
    end
  end

  // Reply frame, first wire byte in the top bits.
  assign reply_vec = {vd_q.req_mac, vd_q.nbr_mac, EtherTypeArp, HwTypeEth, ProtoIpv4,
                      HwLenMac, ProtoLenIp, OpReply, vd_q.nbr_mac, vd_q.nbr_ip,
                      vd_q.req_mac, vd_q.req_ip};
  assign sel = LastIdx - idx_q;

  assign out_valid_o   = busy_q;
  assign reply_byte_o  = vd_q.is_reply ? reply_vec[8*sel +: 8] : 8'd0;
  assign last_of_run_o = last;
  assign status_o      = vd_q.is_reply ? StatusReply : vd_q.status;

endmodule

// ----- rtl/core/arp_request_responder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP request responder, top level
// Captures a transmitted frame, checks it for an ARP request to a configured
// neighbor and answers with a reply frame or a single status item.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per cycle while the input is not stalled. The
// frame's last byte is checked in the cycle after its transfer. A reply is sent
// as 42 bytes, a status as one item; the next finished frame waits (input
// stalls) until the emitter has sent the previous one's last item.
// Reset clears the byte count, control state and all configuration registers.
// ----------------------------------------------------------------------------
module arp_request_responder_top
  import arr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [MacW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      frame_byte_i,
  input  logic            frame_end_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      reply_byte_o,
  output logic            last_of_run_o,
  output logic [1:0]      status_o
);

  logic [MacW-1:0] local_mac_q;
  logic            interface_ready_q;
  logic            src_strict_q;
  logic [1:0]      neighbor_count_q;
  logic [IpW-1:0]  nbr0_ip_q, nbr1_ip_q;
  logic [MacW-1:0] nbr0_mac_q, nbr1_mac_q;

  logic                   load;
  logic                   eval;
  logic [CountW-1:0]      total;
  logic [FrameKeep*8-1:0] store;
  verdict_t               verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_mac_q       <= '0;
      interface_ready_q <= 1'b0;
      src_strict_q      <= 1'b0;
      neighbor_count_q  <= '0;
      nbr0_ip_q         <= '0;
      nbr0_mac_q        <= '0;
      nbr1_ip_q         <= '0;
      nbr1_mac_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLocalMac:       local_mac_q       <= cfg_data_i;
        CfgInterfaceReady: interface_ready_q <= cfg_data_i[0];
        CfgHeaderComplete: src_strict_q      <= cfg_data_i[0];
        CfgNeighborCount:  neighbor_count_q  <= cfg_data_i[1:0];
        CfgNeighbor0Ip:    nbr0_ip_q         <= cfg_data_i[IpW-1:0];
        CfgNeighbor0Mac:   nbr0_mac_q        <= cfg_data_i;
        CfgNeighbor1Ip:    nbr1_ip_q         <= cfg_data_i[IpW-1:0];
        CfgNeighbor1Mac:   nbr1_mac_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  arr_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_byte_i (frame_byte_i),
    .frame_end_i  (frame_end_i),
    .load_i       (load),
    .eval_o       (eval),
    .total_o      (total),
    .store_o      (store)
  );

  arr_check u_check (
    .store_i           (store),
    .total_i           (total),
    .local_mac_i       (local_mac_q),
    .interface_ready_i (interface_ready_q),
    .src_strict_i      (src_strict_q),
    .neighbor_count_i  (neighbor_count_q),
    .nbr0_ip_i         (nbr0_ip_q),
    .nbr0_mac_i        (nbr0_mac_q),
    .nbr1_ip_i         (nbr1_ip_q),
    .nbr1_mac_i        (nbr1_mac_q),
    .verdict_o         (verdict)
  );

  arr_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .eval_i        (eval),
    .verdict_i     (verdict),
    .load_o        (load),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .reply_byte_o  (reply_byte_o),
    .last_of_run_o (last_of_run_o),
    .status_o      (status_o)
  );

endmodule
